@@ rtl/weld_feed_stepper_sequencer_defines.svh @@
// Assertion macros for the weld feed stepper sequencer.
// Depends on nothing; modules that assert include this file and name their clock i_clk
// and their active-low synchronous reset i_rst_n.
`ifndef WELD_FEED_STEPPER_SEQUENCER_DEFINES_SVH
`define WELD_FEED_STEPPER_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset
`define WFSS_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("wfss assertion failed");

// Check a property on every clock edge, reset included
`define WFSS_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) (prop)) \
        else $error("wfss assertion failed");

`else

`define WFSS_ASSERT(label, prop)

`define WFSS_ASSERT_ALWAYS(label, prop)

`endif

`endif

@@ rtl/wfss_pkg.sv @@
// Shared types, constants and a helper function of the weld feed stepper sequencer.
// Depends on nothing; used by every module of the block.
`default_nettype none

package wfss_pkg;

    // Datapath sizes
    localparam int COUNT_BITS  = 16;
    localparam int SENSOR_BITS = 10;
    localparam int WAIT_BITS   = 22;
    localparam int STEPS_W     = 16;
    localparam int CMP_W       = (COUNT_BITS > STEPS_W) ? COUNT_BITS : STEPS_W;
    localparam int PULSE_W     = 8;
    localparam int PHASE_W     = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
    localparam logic [WAIT_BITS-1:0]  WAIT_MAX = '1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FWD_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BWD_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_THRESH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_TICKS  = 3'd6;

    // Reported phase codes
    localparam logic [PHASE_W-1:0] PHC_IDLE    = 3'd0;
    localparam logic [PHASE_W-1:0] PHC_FSETTLE = 3'd1;
    localparam logic [PHASE_W-1:0] PHC_FWD     = 3'd2;
    localparam logic [PHASE_W-1:0] PHC_BSETTLE = 3'd3;
    localparam logic [PHASE_W-1:0] PHC_BWD     = 3'd4;
    localparam logic [PHASE_W-1:0] PHC_DWELL   = 3'd5;

    // Sequencer phases, one-hot
    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_FSETTLE = 6'b000010,
        PH_FWD     = 6'b000100,
        PH_BSETTLE = 6'b001000,
        PH_BWD     = 6'b010000,
        PH_DWELL   = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [15:0]        fwd_step_interval;
        logic [15:0]        bwd_step_interval;
        logic [9:0]         light_threshold;
        logic [15:0]        max_steps;
        logic [PULSE_W-1:0] pulse_width;
        logic [19:0]        settle_ticks;
        logic [21:0]        dwell_ticks;
    } t_cfg;

    typedef struct packed {
        logic               step_pulse;
        logic               direction;
        logic               retract;
        logic [PHASE_W-1:0] phase;
        logic [STEPS_W-1:0] forward_steps;
    } t_result;

    // Map a phase to its reported code
    function automatic logic [PHASE_W-1:0] phase_code(input t_phase ph);
        logic [PHASE_W-1:0] code;
        case (ph)
            PH_FSETTLE: code = PHC_FSETTLE;
            PH_FWD:     code = PHC_FWD;
            PH_BSETTLE: code = PHC_BSETTLE;
            PH_BWD:     code = PHC_BWD;
            PH_DWELL:   code = PHC_DWELL;
            default:    code = PHC_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

@@ rtl/wfss_cfg_regs.sv @@
// Configuration register file of the weld feed stepper sequencer.
// Depends on wfss_pkg.
`default_nettype none

module wfss_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [wfss_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [wfss_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output wfss_pkg::t_cfg                      o_cfg
);
    import wfss_pkg::*;

    t_cfg r_cfg;

    // Load reset values, then take writes masked to each register's width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fwd_step_interval <= 16'd125;
            r_cfg.bwd_step_interval <= 16'd125;
            r_cfg.light_threshold   <= 10'd130;
            r_cfg.max_steps         <= 16'd16000;
            r_cfg.pulse_width       <= 8'd10;
            r_cfg.settle_ticks      <= 20'd10000;
            r_cfg.dwell_ticks       <= 22'd1500000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FWD_INTERVAL: r_cfg.fwd_step_interval <= i_cfg_wdata[15:0];
                CFG_BWD_INTERVAL: r_cfg.bwd_step_interval <= i_cfg_wdata[15:0];
                CFG_LIGHT_THRESH: r_cfg.light_threshold   <= i_cfg_wdata[9:0];
                CFG_MAX_STEPS:    r_cfg.max_steps         <= i_cfg_wdata[15:0];
                CFG_PULSE_WIDTH:  r_cfg.pulse_width       <= i_cfg_wdata[PULSE_W-1:0];
                CFG_SETTLE_TICKS: r_cfg.settle_ticks      <= i_cfg_wdata[19:0];
                CFG_DWELL_TICKS:  r_cfg.dwell_ticks       <= i_cfg_wdata[21:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/wfss_core.sv @@
// Sequencer state and per-tick next-state logic of the weld feed stepper sequencer.
// Depends on wfss_pkg and weld_feed_stepper_sequencer_defines.svh.
`default_nettype none

`include "weld_feed_stepper_sequencer_defines.svh"

module wfss_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire logic                            i_limit_switch,
    input  wire logic [wfss_pkg::SENSOR_BITS-1:0] i_light_level,
    input  wfss_pkg::t_cfg                       i_cfg,
    output wfss_pkg::t_result                    o_res
);
    import wfss_pkg::*;

    t_phase                r_phase, n_phase;
    logic [WAIT_BITS-1:0]  r_wait, n_wait;
    logic [PULSE_W-1:0]    r_pt, n_pt;
    logic [COUNT_BITS-1:0] r_fwd, n_fwd;
    logic [COUNT_BITS-1:0] r_bwd, n_bwd;
    logic                  r_dir, n_dir;
    logic                  r_ret, n_ret;

    logic [WAIT_BITS-1:0]  wait_inc;
    logic [15:0]           st_interval;
    logic [COUNT_BITS-1:0] st_count;
    logic [COUNT_BITS-1:0] st_count_new;
    logic [PULSE_W-1:0]    pw_eff;
    logic [PULSE_W-1:0]    pt_loaded;
    logic [PULSE_W-1:0]    pt_after;
    logic [WAIT_BITS-1:0]  wait_mid;
    logic [WAIT_BITS-1:0]  wait_after;
    logic                  st_start;
    logic                  st_pulse;
    logic                  step;

    // Saturating wait timer increment
    assign wait_inc = (r_wait == WAIT_MAX) ? r_wait : r_wait + 1'b1;

    // Shared step generator, fed by the forward or backward interval and count
    assign st_interval  = (r_phase == PH_BWD) ? i_cfg.bwd_step_interval
                                              : i_cfg.fwd_step_interval;
    assign st_count     = (r_phase == PH_BWD) ? r_bwd : r_fwd;
    assign pw_eff       = (i_cfg.pulse_width == '0) ? PULSE_W'(1) : i_cfg.pulse_width;
    assign st_start     = (r_pt == '0) && (r_wait >= WAIT_BITS'(st_interval));
    assign st_count_new = !st_start ? st_count
                        : (st_count == CNT_MAX) ? st_count : st_count + 1'b1;
    assign pt_loaded    = (r_pt != '0) ? r_pt : (st_start ? pw_eff : '0);
    assign wait_mid     = (r_pt == '0 && !st_start) ? wait_inc : r_wait;
    assign st_pulse     = (pt_loaded != '0);
    assign pt_after     = st_pulse ? pt_loaded - 1'b1 : '0;
    assign wait_after   = (st_pulse && pt_after == '0) ? '0 : wait_mid;

    // Next state for one tick
    always_comb begin
        n_phase = r_phase;
        n_wait  = r_wait;
        n_pt    = r_pt;
        n_fwd   = r_fwd;
        n_bwd   = r_bwd;
        n_dir   = r_dir;
        n_ret   = r_ret;
        step    = 1'b0;
        case (r_phase)
            PH_FSETTLE: begin
                n_wait = wait_inc;
                if (wait_inc >= WAIT_BITS'(i_cfg.settle_ticks)) begin
                    n_phase = PH_FWD;
                    n_wait  = '0;
                end
            end
            PH_FWD: begin
                n_pt   = pt_after;
                n_wait = wait_after;
                n_fwd  = st_count_new;
                step   = st_pulse;
                if (pt_after == '0) begin
                    if (CMP_W'(st_count_new) >= CMP_W'(i_cfg.max_steps)) begin
                        n_ret   = 1'b1;
                        n_dir   = 1'b1;
                        n_phase = PH_BSETTLE;
                        n_wait  = '0;
                    end else if (i_light_level > SENSOR_BITS'(i_cfg.light_threshold)) begin
                        n_ret   = 1'b1;
                        n_dir   = 1'b1;
                        n_phase = PH_BWD;
                        n_wait  = '0;
                    end
                end
            end
            PH_BSETTLE: begin
                n_wait = wait_inc;
                if (wait_inc >= WAIT_BITS'(i_cfg.settle_ticks)) begin
                    n_phase = PH_BWD;
                    n_wait  = '0;
                end
            end
            PH_BWD: begin
                if (r_pt == '0 && r_bwd >= r_fwd) begin
                    n_ret   = 1'b0;
                    n_phase = PH_DWELL;
                    n_wait  = '0;
                end else begin
                    n_pt   = pt_after;
                    n_wait = wait_after;
                    n_bwd  = st_count_new;
                    step   = st_pulse;
                end
            end
            PH_DWELL: begin
                n_wait = wait_inc;
                if (wait_inc >= i_cfg.dwell_ticks) begin
                    n_phase = PH_IDLE;
                    n_wait  = '0;
                end
            end
            default: begin
                if (i_limit_switch) begin
                    n_fwd  = '0;
                    n_bwd  = '0;
                    n_pt   = '0;
                    n_wait = '0;
                    if (r_dir) begin
                        n_dir   = 1'b0;
                        n_phase = PH_FSETTLE;
                    end else begin
                        n_phase = PH_FWD;
                    end
                end else begin
                    n_phase = PH_IDLE;
                end
            end
        endcase
    end

    // Advance the state once per processed transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_wait  <= '0;
            r_pt    <= '0;
            r_fwd   <= '0;
            r_bwd   <= '0;
            r_dir   <= 1'b0;
            r_ret   <= 1'b0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_wait  <= n_wait;
            r_pt    <= n_pt;
            r_fwd   <= n_fwd;
            r_bwd   <= n_bwd;
            r_dir   <= n_dir;
            r_ret   <= n_ret;
        end
    end

    // Result of this tick, as seen after the update
    assign o_res.step_pulse    = step;
    assign o_res.direction     = n_dir;
    assign o_res.retract       = n_ret;
    assign o_res.phase         = phase_code(n_phase);
    assign o_res.forward_steps = STEPS_W'(n_fwd);

    // Retract is held exactly through the back settle and backward phases
    `WFSS_ASSERT(a_retract_phase,
        r_ret == (r_phase == PH_BSETTLE || r_phase == PH_BWD))
    // A pulse is only in flight while stepping
    `WFSS_ASSERT(a_pulse_phase,
        (r_pt != '0) |-> (r_phase == PH_FWD || r_phase == PH_BWD))
    // Direction follows the phase outside idle
    `WFSS_ASSERT(a_dir_phase,
        !((r_phase == PH_FSETTLE || r_phase == PH_FWD) && r_dir) &&
        !((r_phase == PH_BSETTLE || r_phase == PH_BWD || r_phase == PH_DWELL) && !r_dir))
    // State holds while no transaction is processed
    `WFSS_ASSERT(a_hold_when_idle,
        !i_en |=> ($stable(r_phase) && $stable(r_wait) && $stable(r_fwd) && $stable(r_bwd)))

endmodule

`default_nettype wire

@@ rtl/weld_feed_stepper_sequencer.sv @@
// Weld feed stepper sequencer: one input transaction per microsecond tick, carrying the
// limit switch level and a light sample, gives one result transaction with the step output,
// direction, retract, phase and forward step count after that tick. The block takes one
// transaction per clock cycle while the output side does not stall; each passes an input
// register, the combinational sequencer logic and a result register. A stalled result
// stalls the input as soon as the input register is also full. Configuration is written
// through a plain write port; the user must write it only while no transaction is in
// flight, and the block itself does not enforce this. The port has no read-back and an
// unknown index is ignored. Depends on wfss_pkg, wfss_cfg_regs and wfss_core.
`default_nettype none

module weld_feed_stepper_sequencer (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [wfss_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [wfss_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic                             i_limit_switch,
    input  wire logic [wfss_pkg::SENSOR_BITS-1:0] i_light_level,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic                                  o_step_pulse,
    output logic                                  o_direction,
    output logic                                  o_retract,
    output logic [wfss_pkg::PHASE_W-1:0]          o_phase,
    output logic [wfss_pkg::STEPS_W-1:0]          o_forward_steps
);
    import wfss_pkg::*;

    t_cfg                   cfg;
    t_result                core_res;
    t_result                r_res;
    logic                   r_in_valid;
    logic                   r_in_limit;
    logic [SENSOR_BITS-1:0] r_in_light;
    logic                   r_out_valid;
    logic                   advance;
    logic                   fire;
    logic                   in_accept;

    // Move a transaction when the result register is free or being drained
    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    wfss_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    wfss_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (fire),
        .i_limit_switch (r_in_limit),
        .i_light_level  (r_in_light),
        .i_cfg          (cfg),
        .o_res          (core_res)
    );

    // Input register: hold the accepted transaction until the core takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_limit <= i_limit_switch;
            r_in_light <= i_light_level;
        end
    end

    // Result register: load on each processed transaction, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= core_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_step_pulse    = r_res.step_pulse;
    assign o_direction     = r_res.direction;
    assign o_retract       = r_res.retract;
    assign o_phase         = r_res.phase;
    assign o_forward_steps = r_res.forward_steps;

endmodule

`default_nettype wire
